/* rtl/core/sds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants for the sampled derivative stream block.
// ----------------------------------------------------------------------------
package sds_pkg;

   // Quotient bits produced by the divider (one above the 32-bit result)
   localparam int Q_W   = 33;
   // Width of the divisor (square of a 32-bit spacing magnitude)
   localparam int DEN_W = 64;

   // Register value that selects the second derivative
   localparam logic [1:0] ORDER_SECOND = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_SHORT = 2'd1;
   localparam logic [1:0] STAT_SAT   = 2'd2;

   // Saturation limits
   localparam logic [31:0] RES_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] RES_MIN = 32'h8000_0000;

   // Which point of the run is being worked out
   typedef enum logic [1:0] {
      TERM_HEAD,
      TERM_MID,
      TERM_TAIL
   } term_type;

   // What goes into the output register
   typedef enum logic [1:0] {
      SEL_SHORT,
      SEL_RESULT,
      SEL_LAST
   } sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic     capture;
      logic     shift;
      term_type term;
      logic     setup;
      logic     mult;
      logic     div_init;
      logic     div_step;
      logic     finish;
      logic     load_out;
      sel_type  out_sel;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic fin;
      logic two;
      logic out_free;
   } sts_type;

endpackage

/* rtl/core/sampled_derivative_stream.sv */
`timescale 1ns / 1ps
// A result passes decide, setup, square, divider load, the divider steps (one per quotient
// bit), saturate and output load before it is presented; a short-run result goes from decide
// straight to output load. A new sample is taken only in idle, after the last one's results
// are loaded; each further result of the same sample runs again through the one shared
// restoring divider (a copied last point does not); output stalls hold the sequencer in emit.
// Reset: synchronous, active high; clears the run, selects first derivative.
// ----------------------------------------------------------------------------
// sampled_derivative_stream
// Finite-difference derivative of a Q16.16 sample stream on a non-uniform grid.
// ----------------------------------------------------------------------------
module sampled_derivative_stream #(
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] sample_value, [63:32] sample_position
   input  logic        req_tlast,   // final_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] derivative
   output logic        rsp_tlast,   // run_end
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data  // derivative_order
);

   sds_pkg::cmd_type cmd;
   sds_pkg::sts_type sts;

   // sequencer
   sds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // arithmetic and storage
   sds_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

/* rtl/core/sds_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_datapath
// Sample history, difference and square unit, shared restoring divider,
// saturation and the output register.
// ----------------------------------------------------------------------------
module sds_datapath #(
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  sds_pkg::cmd_type  cmd,
   output sds_pkg::sts_type  sts,
   input  logic [63:0]       req_tdata,   // [31:0] sample_value, [63:32] sample_position
   input  logic              req_tlast,   // final_sample
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data, // derivative_order
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [31:0] derivative
   output logic              rsp_tlast,   // run_end
   output logic [1:0]        rsp_tuser    // [1:0] status
);

   localparam int NUM_W = 2 * FRACTION_BITS + 36;
   localparam int HI_W  = NUM_W - sds_pkg::Q_W;

   // configuration and captured transaction
   logic [1:0]  order_ff;
   logic        two_ff, fin_ff;
   logic [31:0] cur_val_ff, cur_pos_ff;
   // history, index 0 newest
   logic [31:0] val0_ff, val1_ff, pos0_ff, pos1_ff;
   // operand and divider registers
   logic [33:0] nmag_ff, nmag_in;
   logic        neg_ff, neg_in;
   logic [31:0] dmag_ff, dmag_in;
   logic [sds_pkg::DEN_W-1:0] den_ff;
   logic [NUM_W-1:0]          num_ff;
   logic [sds_pkg::DEN_W-1:0] rem_ff;
   logic [sds_pkg::Q_W-1:0]   quo_ff;
   logic                      big_ff;
   logic [31:0] res_ff, res_in;
   logic [1:0]  stat_ff, stat_in;
   // output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_last_ff;
   logic [1:0]  rsp_user_ff;

   logic [31:0] fa, fb, xa, xb;
   logic [32:0] n1, d1;
   logic [33:0] n2, n_sel, n_abs;
   logic [32:0] d_abs;
   logic [63:0] dsq;
   logic [NUM_W-1:0] num_in;
   logic [HI_W-1:0]  hi;
   logic [sds_pkg::DEN_W:0] trial;

   assign sts.fin      = fin_ff;
   assign sts.two      = two_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 2'd1;
      end else if (csr_wr_en) begin
         order_ff <= csr_wr_data;
      end
   end

   // capture and history
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_val_ff <= req_tdata[31:0];
         cur_pos_ff <= req_tdata[63:32];
         fin_ff     <= req_tlast;
         two_ff     <= (order_ff == sds_pkg::ORDER_SECOND);
      end
      if (cmd.shift) begin
         val1_ff <= val0_ff;
         pos1_ff <= pos0_ff;
         val0_ff <= cur_val_ff;
         pos0_ff <= cur_pos_ff;
      end
   end

   // operand selection per term
   always_comb begin
      case (cmd.term)
         sds_pkg::TERM_HEAD: begin
            fa = val0_ff;    fb = val1_ff;
            xa = pos0_ff;    xb = pos1_ff;
         end
         sds_pkg::TERM_MID: begin
            fa = cur_val_ff; fb = val1_ff;
            xa = cur_pos_ff; xb = pos1_ff;
         end
         sds_pkg::TERM_TAIL: begin
            fa = cur_val_ff; fb = val0_ff;
            xa = cur_pos_ff; xb = pos0_ff;
         end
         default: begin
            fa = cur_val_ff; fb = val0_ff;
            xa = cur_pos_ff; xb = pos0_ff;
         end
      endcase
   end

   // differences, magnitudes and quotient sign
   always_comb begin
      n1 = {fa[31], fa} - {fb[31], fb};
      d1 = {xa[31], xa} - {xb[31], xb};
      n2 = {{2{cur_val_ff[31]}}, cur_val_ff} - {val0_ff[31], val0_ff, 1'b0}
         + {{2{val1_ff[31]}}, val1_ff};
      n_sel   = two_ff ? n2 : {n1[32], n1};
      n_abs   = n_sel[33] ? (34'd0 - n_sel) : n_sel;
      d_abs   = d1[32] ? (33'd0 - d1) : d1;
      nmag_in = n_abs;
      dmag_in = d_abs[31:0];
      neg_in  = two_ff ? n_sel[33] : (n1[32] ^ d1[32]);
   end

   // divisor and scaled numerator
   assign dsq = dmag_ff * dmag_ff;

   always_comb begin
      if (two_ff && cmd.term == sds_pkg::TERM_MID) begin
         num_in = NUM_W'(nmag_ff) << (2 * FRACTION_BITS + 2);
      end else if (two_ff) begin
         num_in = NUM_W'(nmag_ff) << (2 * FRACTION_BITS);
      end else begin
         num_in = NUM_W'(nmag_ff) << FRACTION_BITS;
      end
   end

   // top numerator bits seed the remainder; the rest are shifted in
   assign hi    = num_ff[NUM_W-1:sds_pkg::Q_W];
   assign trial = {rem_ff, quo_ff[sds_pkg::Q_W-1]} - {1'b0, den_ff};

   // saturation and status
   always_comb begin
      if (den_ff == '0) begin
         stat_in = sds_pkg::STAT_SAT;
         if (nmag_ff == '0) begin
            res_in = 32'd0;
         end else begin
            res_in = neg_ff ? sds_pkg::RES_MIN : sds_pkg::RES_MAX;
         end
      end else if (neg_ff) begin
         if (big_ff || quo_ff > 33'h0_8000_0000) begin
            stat_in = sds_pkg::STAT_SAT;
            res_in  = sds_pkg::RES_MIN;
         end else begin
            stat_in = sds_pkg::STAT_OK;
            res_in  = 32'd0 - quo_ff[31:0];
         end
      end else begin
         if (big_ff || quo_ff[32:31] != 2'b00) begin
            stat_in = sds_pkg::STAT_SAT;
            res_in  = sds_pkg::RES_MAX;
         end else begin
            stat_in = sds_pkg::STAT_OK;
            res_in  = quo_ff[31:0];
         end
      end
   end

   // arithmetic pipeline and divider iterations
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         nmag_ff <= nmag_in;
         dmag_ff <= dmag_in;
         neg_ff  <= neg_in;
      end
      if (cmd.mult) begin
         den_ff <= two_ff ? dsq : {32'd0, dmag_ff};
         num_ff <= num_in;
      end
      if (cmd.div_init) begin
         rem_ff <= sds_pkg::DEN_W'(hi);
         big_ff <= (sds_pkg::DEN_W'(hi) >= den_ff);
         quo_ff <= num_ff[sds_pkg::Q_W-1:0];
      end else if (cmd.div_step) begin
         if (!trial[sds_pkg::DEN_W]) begin
            rem_ff <= trial[sds_pkg::DEN_W-1:0];
         end else begin
            rem_ff <= {rem_ff[sds_pkg::DEN_W-2:0], quo_ff[sds_pkg::Q_W-1]};
         end
         quo_ff <= {quo_ff[sds_pkg::Q_W-2:0], ~trial[sds_pkg::DEN_W]};
      end
      if (cmd.finish) begin
         res_ff  <= res_in;
         stat_ff <= stat_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         case (cmd.out_sel)
            sds_pkg::SEL_SHORT: begin
               rsp_data_ff <= 32'd0;
               rsp_last_ff <= 1'b1;
               rsp_user_ff <= sds_pkg::STAT_SHORT;
            end
            sds_pkg::SEL_RESULT: begin
               rsp_data_ff <= res_ff;
               rsp_last_ff <= 1'b0;
               rsp_user_ff <= stat_ff;
            end
            default: begin
               rsp_data_ff <= res_ff;
               rsp_last_ff <= 1'b1;
               rsp_user_ff <= stat_ff;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* rtl/core/sds_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_ctrl
// Sequencer: run bookkeeping, term order and divider iteration count.
// ----------------------------------------------------------------------------
module sds_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sds_pkg::sts_type  sts,
   output sds_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SETUP,
      ST_MULT,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_FINISH,
      ST_EMIT
   } state_type;

   localparam int STEP_W = $clog2(sds_pkg::Q_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(sds_pkg::Q_W - 1);

   state_type          state_ff;
   logic [1:0]         seen_ff;
   logic               head_ff;
   sds_pkg::term_type  term_ff;
   sds_pkg::sel_type   sel_ff;
   logic [STEP_W-1:0]  step_ff;

   logic mid_done;

   assign req_tready = (state_ff == ST_IDLE);
   // middle point just left without ending the run
   assign mid_done = (state_ff == ST_EMIT) && sts.out_free
                  && (sel_ff == sds_pkg::SEL_RESULT)
                  && (term_ff == sds_pkg::TERM_MID) && !sts.fin;

   // command decode
   always_comb begin
      cmd          = '0;
      cmd.term     = term_ff;
      cmd.out_sel  = sel_ff;
      cmd.capture  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.shift    = ((state_ff == ST_DECIDE) && seen_ff != 2'd2 && !sts.fin) || mid_done;
      cmd.setup    = (state_ff == ST_SETUP);
      cmd.mult     = (state_ff == ST_MULT);
      cmd.div_init = (state_ff == ST_DIV_INIT);
      cmd.div_step = (state_ff == ST_DIV_STEP);
      cmd.finish   = (state_ff == ST_FINISH);
      cmd.load_out = (state_ff == ST_EMIT) && sts.out_free;
   end

   // state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= 2'd0;
         head_ff  <= 1'b0;
         term_ff  <= sds_pkg::TERM_HEAD;
         sel_ff   <= sds_pkg::SEL_RESULT;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (seen_ff != 2'd2) begin
                  if (sts.fin) begin
                     sel_ff   <= sds_pkg::SEL_SHORT;
                     state_ff <= ST_EMIT;
                  end else begin
                     seen_ff  <= seen_ff + 2'd1;
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  term_ff  <= head_ff ? sds_pkg::TERM_MID : sds_pkg::TERM_HEAD;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               state_ff <= ST_MULT;
            end
            ST_MULT: begin
               state_ff <= ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
               step_ff  <= '0;
               state_ff <= ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_LAST) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               sel_ff   <= (term_ff == sds_pkg::TERM_TAIL) ? sds_pkg::SEL_LAST
                                                           : sds_pkg::SEL_RESULT;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (sts.out_free) begin
                  if (sel_ff != sds_pkg::SEL_RESULT) begin
                     // run finished: back to the start of a run
                     seen_ff  <= 2'd0;
                     head_ff  <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else if (term_ff == sds_pkg::TERM_HEAD) begin
                     head_ff  <= 1'b1;
                     term_ff  <= sds_pkg::TERM_MID;
                     state_ff <= ST_SETUP;
                  end else if (sts.fin && sts.two) begin
                     // second derivative: last point repeats the one before
                     sel_ff   <= sds_pkg::SEL_LAST;
                  end else if (sts.fin) begin
                     term_ff  <= sds_pkg::TERM_TAIL;
                     state_ff <= ST_SETUP;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // checks
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("output register loaded while occupied");

   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff != 2'd3)
      else $error("sample count beyond two");

   a_head_needs_two: assert property (@(posedge clock) disable iff (reset)
      head_ff |-> seen_ff == 2'd2)
      else $error("first point emitted before two samples held");

   a_tail_first_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP && term_ff == sds_pkg::TERM_TAIL) |-> (sts.fin && !sts.two))
      else $error("backward difference outside a first-order run end");

   a_shift_not_final: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> !sts.fin)
      else $error("history shifted on the final sample");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sampled_derivative_stream. Directed runs cover short
// runs, saturation, zero spacing, second-derivative runs and an order change
// inside a run; random runs follow in three phases of back-pressure. A
// scoreboard predicts every result from the accepted samples and checks the
// result stream in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          FRAC_BITS     = 16;
   localparam int          SETTLE_CYCLES = 48;
   localparam int          PHASE_SAMPLES = 46;
   localparam int          TIMEOUT_NS    = 2_000_000;
   // Register values that select the first derivative
   localparam logic [1:0]  ORDER_LOW     = 2'd0;
   localparam logic [1:0]  ORDER_FIRST   = 2'd1;
   localparam logic [1:0]  ORDER_HIGH    = 2'd3;

   typedef struct {
      logic [31:0] derivative;
      logic        run_end;
      logic [1:0]  status;
   } point_type;

   // Scoreboard: holds its own copy of the run state and the order register
   class derivative_scoreboard;
      point_type   expected_points[$];
      longint      held_value[2];    // index 0 newest
      longint      held_position[2];
      int unsigned held_count;
      bit          head_done;
      logic [1:0]  order_reg;
      int unsigned error_count;

      function new();
         clear_run();
         order_reg   = ORDER_FIRST;
         error_count = 0;
      endfunction

      function void clear_run();
         held_value[0]    = 0;
         held_value[1]    = 0;
         held_position[0] = 0;
         held_position[1] = 0;
         held_count       = 0;
         head_done        = 1'b0;
      endfunction

      function void set_order(logic [1:0] value);
         order_reg = value;
      endfunction

      function logic [127:0] magnitude(longint v);
         return (v < 0) ? 128'(-v) : 128'(v);
      endfunction

      // Signed quotient truncated toward zero, saturated to 32 bits
      function void quotient(input logic [127:0] num_mag, input bit neg, input int shift,
                             input logic [127:0] den, output logic [31:0] res,
                             output logic [1:0] st);
         logic [127:0] q;
         if (den == 0) begin
            st  = sds_pkg::STAT_SAT;
            res = (num_mag == 0) ? 32'd0 : (neg ? sds_pkg::RES_MIN : sds_pkg::RES_MAX);
            return;
         end
         q = (num_mag << shift) / den;
         if (neg) begin
            if (q > 128'h8000_0000) begin
               st  = sds_pkg::STAT_SAT;
               res = sds_pkg::RES_MIN;
            end else begin
               st  = sds_pkg::STAT_OK;
               res = 32'd0 - q[31:0];
            end
         end else begin
            if (q > 128'h7FFF_FFFF) begin
               st  = sds_pkg::STAT_SAT;
               res = sds_pkg::RES_MAX;
            end else begin
               st  = sds_pkg::STAT_OK;
               res = q[31:0];
            end
         end
      endfunction

      // (fa - fb) / (xa - xb)
      function void slope(input longint fa, input longint fb, input longint xa,
                          input longint xb, output logic [31:0] res, output logic [1:0] st);
         longint n;
         longint d;
         n = fa - fb;
         d = xa - xb;
         quotient(magnitude(n), (n < 0) != (d < 0), FRAC_BITS, magnitude(d), res, st);
      endfunction

      // (f2 - 2 f1 + f0) * 2^extra / d^2
      function void curvature(input longint f0, input longint f1, input longint f2,
                              input longint d, input int extra, output logic [31:0] res,
                              output logic [1:0] st);
         longint       n;
         logic [127:0] dm;
         n  = f2 - 2 * f1 + f0;
         dm = magnitude(d);
         quotient(magnitude(n) << extra, n < 0, 2 * FRAC_BITS, dm * dm, res, st);
      endfunction

      function void push(logic [31:0] res, logic last, logic [1:0] st);
         point_type p;
         p.derivative = res;
         p.run_end    = last;
         p.status     = st;
         expected_points.push_back(p);
      endfunction

      // Called once per accepted input transaction
      function void note_sample(logic [31:0] value, logic [31:0] position, logic last);
         longint      f0, f1, f2, x0, x1, x2;
         bit          two;
         logic [31:0] res;
         logic [1:0]  st;
         f2  = $signed(value);
         x2  = $signed(position);
         two = (order_reg == sds_pkg::ORDER_SECOND);
         // filling: fewer than two samples held
         if (held_count < 2) begin
            if (last) begin
               clear_run();
               push(32'd0, 1'b1, sds_pkg::STAT_SHORT);
               return;
            end
            held_value[1]    = held_value[0];
            held_position[1] = held_position[0];
            held_value[0]    = f2;
            held_position[0] = x2;
            held_count++;
            return;
         end
         f0 = held_value[1];
         x0 = held_position[1];
         f1 = held_value[0];
         x1 = held_position[0];
         // first point of the run, only once
         if (!head_done) begin
            if (two) curvature(f0, f1, f2, x1 - x0, 0, res, st);
            else slope(f1, f0, x1, x0, res, st);
            push(res, 1'b0, st);
            head_done = 1'b1;
         end
         // inner point
         if (two) curvature(f0, f1, f2, x2 - x0, 2, res, st);
         else slope(f2, f0, x2, x0, res, st);
         push(res, 1'b0, st);
         // last point: backward difference, or a copy of the inner one
         if (last) begin
            if (!two) slope(f2, f1, x2, x1, res, st);
            push(res, 1'b1, st);
            clear_run();
            return;
         end
         held_value[1]    = f1;
         held_position[1] = x1;
         held_value[0]    = f2;
         held_position[0] = x2;
      endfunction

      // Called once per accepted result transaction
      function void check_result(logic [31:0] derivative, logic last, logic [1:0] st);
         point_type want;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result derivative %h run_end %b status %0d",
                     $time, derivative, last, st);
            error_count++;
            return;
         end
         want = expected_points.pop_front();
         if (derivative !== want.derivative || last !== want.run_end || st !== want.status) begin
            $display("%0t: mismatch expected derivative %h run_end %b status %0d, got %h %b %0d",
                     $time, want.derivative, want.run_end, want.status, derivative, last, st);
            error_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // [31:0] sample_value, [63:32] sample_position
   logic        req_tlast;    // final_sample
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] derivative
   logic        rsp_tlast;    // run_end
   logic [1:0]  rsp_tuser;    // [1:0] status
   logic        csr_wr_en;
   logic [1:0]  csr_wr_data;  // derivative_order

   derivative_scoreboard board = new();
   int unsigned tx_idle_pct = 7;
   int unsigned rx_idle_pct = 74;
   int unsigned samples_sent = 0;

   sampled_derivative_stream #(
      .FRACTION_BITS (FRAC_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Sample transaction with random gaps; valid stays high between back-to-back items
   task automatic send_sample(input logic [31:0] value, input logic [31:0] position,
                              input logic last);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {position, value};
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_sample(value, position, last);
      samples_sent++;
   endtask

   // Hold off until every expected result is back and the block has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(input logic [1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_order(value);
   endtask

   // Mostly well-formed runs with rising positions, some repeated; some short or pure noise
   task automatic send_random_run();
      int unsigned kind;
      int unsigned len;
      logic [31:0] value;
      logic [31:0] position;
      kind     = $urandom_range(9);
      len      = (kind == 0) ? $urandom_range(1, 6) :
                 (kind == 1) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      position = $urandom();
      value    = $signed($urandom()) >>> $urandom_range(0, 16);
      for (int k = 0; k < len; k++) begin
         if (kind == 0) begin
            value    = $urandom();
            position = $urandom();
         end
         send_sample(value, position, k == len - 1);
         position += ($urandom_range(11) == 0) ? 32'd0 : $urandom_range(1, 32'h0004_0000);
         value    += $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      end
   endtask

   // Result side: random ready, check on every accepted transaction
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            board.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Main stimulus
   initial begin
      int unsigned phase_target;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= ORDER_FIRST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // short runs: one sample, then two
      send_sample(32'h0005_0000, 32'h0000_0000, 1'b1);
      send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_sample(32'h0001_0000, 32'h0001_0000, 1'b1);
      // three-sample run at the field extremes, saturating
      send_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 32'h8000_0001, 1'b0);
      send_sample(32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
      // zero spacing with negative and zero numerators
      send_sample(32'h0003_0000, 32'h0001_0000, 1'b0);
      send_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
      send_sample(32'h0003_0000, 32'h0001_0000, 1'b0);
      send_sample(32'h0004_0000, 32'h0002_0000, 1'b1);

      // second derivative of x^2, last point copied
      drain();
      write_order(sds_pkg::ORDER_SECOND);
      send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
      send_sample(32'h0004_0000, 32'h0002_0000, 1'b0);
      send_sample(32'h0009_0000, 32'h0003_0000, 1'b0);
      send_sample(32'h0010_0000, 32'h0004_0000, 1'b1);
      // zero spacing at the head with a positive numerator
      send_sample(32'h0000_0000, 32'h0001_0000, 1'b0);
      send_sample(32'h0000_0000, 32'h0001_0000, 1'b0);
      send_sample(32'h0001_0000, 32'h0002_0000, 1'b1);

      // order change while two samples are held
      send_sample(32'h0002_0000, 32'hFFFF_0000, 1'b0);
      send_sample(32'hFFFF_0000, 32'h0000_8000, 1'b0);
      drain();
      write_order(ORDER_LOW);
      send_sample(32'h0001_8000, 32'h0001_0000, 1'b0);
      send_sample(32'h0000_4000, 32'h0003_0000, 1'b1);

      // random runs in three back-pressure phases
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 74 : 0;
         rx_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 7 : 0;
         drain();
         write_order((phase == 0) ? ORDER_HIGH :
                     (phase == 1) ? sds_pkg::ORDER_SECOND : ORDER_FIRST);
         phase_target = samples_sent + PHASE_SAMPLES;
         while (samples_sent < phase_target) begin
            if ($urandom_range(3) == 0) begin
               drain();
               write_order(2'($urandom_range(3)));
            end
            send_random_run();
         end
      end

      drain();
      if (board.error_count == 0 && board.expected_points.size() == 0)
         $display("sampled_derivative_stream test passed");
      else
         $display("sampled_derivative_stream test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("sampled_derivative_stream test failed");
      $finish;
   end

endmodule
